// File: hdl/crdo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crdo_pkg
// Types shared by the sorting cells and the top level of the C-SCAN orderer.
// ----------------------------------------------------------------------------
package crdo_pkg;

  localparam int unsigned CYL_W  = 16;
  localparam int unsigned MOVE_W = 17;

  // one stored request
  typedef struct packed {
    logic             valid;
    logic             wrapped;  // moved behind the rest, served after the wrap
    logic [CYL_W-1:0] value;
  } cell_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_CLEAR  = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_ROTATE = 3'd3,
    CELL_SHIFT  = 3'd4
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [CYL_W-1:0] value;  // new request on insert, front value on rotate
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/crdo_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crdo_cell
// One cell of the descending insertion-sort chain. Clears, inserts, rotates the
// front entry to the tail, or shifts towards the front.
// ----------------------------------------------------------------------------
module crdo_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire crdo_pkg::cell_ctrl_t ctrl,
  input  wire crdo_pkg::cell_t     prev_cell,
  input  wire logic                prev_ins,
  input  wire crdo_pkg::cell_t     next_cell,
  output logic                     ins,
  output crdo_pkg::cell_t          slot
);

  crdo_pkg::cell_t slot_next;
  logic            tail;

  // new value belongs at or in front of this cell
  assign ins  = !slot.valid || (slot.value < ctrl.value);
  assign tail = slot.valid && !next_cell.valid;

  always_comb begin
    slot_next = slot;
    unique case (ctrl.op)
      crdo_pkg::CELL_HOLD: begin
        slot_next = slot;
      end
      crdo_pkg::CELL_CLEAR: begin
        slot_next.valid = 1'b0;
      end
      crdo_pkg::CELL_INSERT: begin
        if (ins) begin
          if (prev_ins) begin
            slot_next = prev_cell;
          end else begin
            slot_next.valid   = 1'b1;
            slot_next.wrapped = 1'b0;
            slot_next.value   = ctrl.value;
          end
        end
      end
      crdo_pkg::CELL_ROTATE: begin
        if (tail) begin
          slot_next.valid   = 1'b1;
          slot_next.wrapped = 1'b1;
          slot_next.value   = ctrl.value;
        end else begin
          slot_next = next_cell;
        end
      end
      crdo_pkg::CELL_SHIFT: begin
        slot_next = next_cell;
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cscan_disk_request_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cscan_disk_request_order
// Downward C-SCAN ordering: requests are insertion-sorted into a cell chain as
// they arrive, one per cycle; the end of a job drains the ordered run.
// Throughput: one input transaction per cycle while a job loads.
// After the ending transaction, the chain rotates each request above the head
// behind the rest, the head result is loaded, then one result per cycle while
// the output is free, count+1 in all. Inputs are held off while a job drains.
// Reset empties the chain and clears head, overflow flag and output valid.
// ----------------------------------------------------------------------------
module cscan_disk_request_order #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          in_valid,
  output logic                                in_ready,
  input  wire  logic [crdo_pkg::CYL_W-1:0]    cylinder,
  input  wire  logic                          starts_job,
  input  wire  logic                          ends_job,
  output logic                                out_valid,
  input  wire  logic                          out_ready,
  output logic [crdo_pkg::CYL_W-1:0]          served_cylinder,
  output logic [crdo_pkg::MOVE_W-1:0]         total_movement,
  output logic                                last_of_run,
  output logic                                overflowed
);

  localparam int unsigned CW = crdo_pkg::CYL_W;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_ROT   = 4'b0010,
    S_HEAD  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t              state;
  logic [CW-1:0]       head_cylinder;
  logic                overflow_seen;
  logic [CW-1:0]       low;
  logic [CW-1:0]       hi;
  logic                seen_above;

  crdo_pkg::cell_ctrl_t ctrl;
  crdo_pkg::cell_t      cells [MAX_REQUESTS+1];
  logic                 ins   [MAX_REQUESTS];

  logic                 accept;
  logic                 out_free;
  logic                 emit;
  logic                 full;
  logic                 rot_go;
  logic                 drain_last;
  crdo_pkg::cell_t      front;
  logic [CW-1:0]        low_eff;
  logic [CW-1:0]        hi_eff;
  logic [CW-1:0]        first_term;
  logic [CW-1:0]        second_term;
  logic [crdo_pkg::MOVE_W-1:0] move_sum;

  // ------------------------------------------------------------------ chain
  assign cells[MAX_REQUESTS] = '0;

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      crdo_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .prev_cell ('0),
        .prev_ins  (1'b0),
        .next_cell (cells[i+1]),
        .ins       (ins[i]),
        .slot      (cells[i])
      );
    end else begin : g_rest
      crdo_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .prev_cell (cells[i-1]),
        .prev_ins  (ins[i-1]),
        .next_cell (cells[i+1]),
        .ins       (ins[i]),
        .slot      (cells[i])
      );
    end
  end

  // ---------------------------------------------------------------- control
  assign front      = cells[0];
  assign full       = cells[MAX_REQUESTS-1].valid;
  assign in_ready   = (state == S_LOAD);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  // a result transaction is loaded into the output register this cycle
  assign emit       = out_free && ((state == S_HEAD) || (state == S_DRAIN));
  // requests above the head go behind those at or below it
  assign rot_go     = front.valid && !front.wrapped && (front.value > head_cylinder);
  assign drain_last = !cells[1].valid;

  always_comb begin
    ctrl.op    = crdo_pkg::CELL_HOLD;
    ctrl.value = cylinder;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (starts_job) begin
            ctrl.op = crdo_pkg::CELL_CLEAR;
          end else if (!full) begin
            ctrl.op = crdo_pkg::CELL_INSERT;
          end
        end
      end
      S_ROT: begin
        ctrl.value = front.value;
        if (rot_go) begin
          ctrl.op = crdo_pkg::CELL_ROTATE;
        end
      end
      S_HEAD: begin
        ctrl.op = crdo_pkg::CELL_HOLD;
      end
      S_DRAIN: begin
        if (out_free) begin
          ctrl.op = crdo_pkg::CELL_SHIFT;
        end
      end
      default: begin
        ctrl.op = crdo_pkg::CELL_HOLD;
      end
    endcase
  end

  // movement for the final result of a drain
  always_comb begin
    low_eff     = front.wrapped ? low : front.value;
    hi_eff      = seen_above ? hi : front.value;
    first_term  = head_cylinder - low_eff;
    second_term = front.wrapped ? (hi_eff - front.value) : '0;
    move_sum    = {1'b0, first_term} + {1'b0, second_term};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      head_cylinder <= '0;
      overflow_seen <= 1'b0;
      seen_above    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (starts_job) begin
              head_cylinder <= cylinder;
              overflow_seen <= 1'b0;
            end else if (full) begin
              overflow_seen <= 1'b1;
            end
            if (ends_job) begin
              state <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (!rot_go) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            served_cylinder <= head_cylinder;
            last_of_run     <= !front.valid;
            total_movement  <= '0;
            overflowed      <= overflow_seen;
            low             <= head_cylinder;
            seen_above      <= 1'b0;
            if (front.valid) begin
              state <= S_DRAIN;
            end else begin
              state         <= S_LOAD;
              overflow_seen <= 1'b0;
            end
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            served_cylinder <= front.value;
            last_of_run     <= drain_last;
            total_movement  <= drain_last ? move_sum : '0;
            overflowed      <= overflow_seen;
            if (!front.wrapped) begin
              low <= front.value;
            end else if (!seen_above) begin
              hi         <= front.value;
              seen_above <= 1'b1;
            end
            if (drain_last) begin
              state         <= S_LOAD;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
